FILE: src/ogrup_pkg.sv
package ogrup_pkg;

  typedef enum logic [1:0] {
    ACT_RAY   = 2'd0,
    ACT_SCAN  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH       = 3'd0,
    CFG_GRID_HEIGHT      = 3'd1,
    CFG_ORIGIN_X         = 3'd2,
    CFG_ORIGIN_Y         = 3'd3,
    CFG_CELLS_PER_METER  = 3'd4,
    CFG_HIT_DELTA        = 3'd5,
    CFG_MISS_DELTA       = 3'd6,
    CFG_SCANS_PER_SUBMAP = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MUL,
    ST_CAP,
    ST_PLAN,
    ST_DIV_X,
    ST_WAIT_X,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_STEP_RD,
    ST_STEP_WR,
    ST_END_RD,
    ST_END_WR,
    ST_Q_RD,
    ST_Q_WAIT,
    ST_OUT
  } state_e;

  localparam int unsigned LW = 12;
  localparam logic signed [LW-1:0] LO_MAX = 12'sd1024;
  localparam logic signed [LW-1:0] LO_MIN = -12'sd1024;
  localparam logic [15:0] SCAN_SAT = 16'hFFFF;
  localparam logic [15:0] SCAN_ENOUGH = 16'd3;

  localparam logic [8:0]  RST_GRID_WIDTH = 9'd256;
  localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;
  localparam logic [23:0] RST_CELLS_PER_METER = 24'd1310720;
  localparam logic signed [LW-1:0] RST_HIT_DELTA = 12'sd51;
  localparam logic signed [LW-1:0] RST_MISS_DELTA = -12'sd10;
  localparam logic [15:0] RST_SCANS_PER_SUBMAP = 16'd100;

  function automatic logic signed [LW-1:0] sat_add(logic signed [LW-1:0] a,
                                                   logic signed [LW-1:0] b);
    logic signed [LW:0] s;
    s = {a[LW-1], a} + {b[LW-1], b};
    if (s > 13'sd1024) begin
      return LO_MAX;
    end else if (s < -13'sd1024) begin
      return LO_MIN;
    end
    return s[LW-1:0];
  endfunction

  function automatic logic signed [32:0] diff33(logic signed [31:0] a,
                                                logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

endpackage

FILE: src/ogrup_mul.sv
module ogrup_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic [23:0]        b_i,
  output logic signed [57:0] p_o
);

  logic signed [57:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 58'(a_i) * 58'($signed({1'b0, b_i}));
  end

  assign p_o = p_q;

endmodule

FILE: src/ogrup_div.sv
module ogrup_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [VW:0]     rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   dvs_q, dvs_d;
  logic [VW:0]     shifted;
  logic [VW+1:0]   trial;
  logic            ge;

  assign shifted = {rem_q[VW-1:0], quo_q[DW-1]};
  assign trial = {1'b0, shifted} - (VW+2)'(dvs_q);
  assign ge = !trial[VW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CNTW'(DW);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[VW:0] : shifted;
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: src/ogrup_mem.sv
module ogrup_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/occupancy_grid_ray_update_core.sv
// channel | dir | handshake                     | payload
// input   | in  | s_axis_tvalid / s_axis_tready | tuser action, tdata sensor and point
// result  | out | m_axis_tvalid / m_axis_tready | tdata log-odds, flags, scan count
// config  | in  | cfg_we_i                      | cfg_index_i, cfg_wdata_i
//
// A ray converts its four coordinates in turn on the shared multiplier, takes a planning
// step, runs two divisions on the serial divider (start, shift steps, done), then does a
// read-modify-write per traversed cell plus one for the hit cell (one RAM port).
// Queries convert the coordinates and read the point's cell; scan marks go straight
// to the output word.
// After reset a clearing pass writes zero to all MAX_GRID_WIDTH*MAX_GRID_HEIGHT
// cells, one a cycle, before the first word is taken. A held result stalls input.
module occupancy_grid_ray_update_core #(
  parameter int unsigned MAX_GRID_WIDTH = 256,
  parameter int unsigned MAX_GRID_HEIGHT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sensor_x[31:0], sensor_y[63:32], point_x[95:64], point_y[127:96]
  input  logic [127:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cell_log_odds[11:0], in_map[12], ray_applied[13], scan_count[29:14],
  // finished[30], enough_data[31]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i
);

  import ogrup_pkg::*;

  localparam int unsigned MAXD = (MAX_GRID_WIDTH > MAX_GRID_HEIGHT) ?
                                 MAX_GRID_WIDTH : MAX_GRID_HEIGHT;
  localparam int unsigned CW = $clog2(MAXD);
  localparam int unsigned SW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int unsigned DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DVW = CW + 16;
  localparam int unsigned PW = CW + 18;

  state_e state_q, state_d;

  logic [8:0]         grid_width_q, grid_height_q;
  logic signed [31:0] origin_x_q, origin_y_q;
  logic [23:0]        cpm_q;
  logic signed [LW-1:0] hit_delta_q, miss_delta_q;
  logic [15:0]        spsm_q;
  logic [15:0]        scans_q;

  action_e            act_q;
  logic signed [31:0] in_sx_q, in_sy_q, in_px_q, in_py_q;

  logic [1:0]         conv_idx_q;
  logic [CW-1:0]      cell_q [4];
  logic [3:0]         cin_q;

  logic [CW-1:0]      adx_q, ady_q, steps_q, step_cnt_q;
  logic               dxneg_q, dyneg_q;
  logic signed [17:0] incx_q, incy_q;
  logic signed [PW-1:0] posx_q, posy_q;
  logic [AW-1:0]      cur_addr_q;
  logic               cur_ok_q;
  logic [AW-1:0]      clr_q;

  logic               out_valid_q;
  logic signed [LW-1:0] out_lo_q;
  logic               out_inmap_q, out_applied_q;

  logic [SW-1:0]      eff_w, eff_h;
  logic signed [32:0] mul_a;
  logic signed [57:0] mul_p;
  logic signed [25:0] conv_cell;
  logic [25:0]        conv_eff;
  logic               conv_in;

  logic               div_start, div_done;
  logic [DVW-1:0]     div_dividend, div_quot;
  logic [CW-1:0]      div_divisor;
  logic signed [17:0] div_q;
  logic signed [17:0] div_inc;

  logic signed [PW-1:0] rxw, ryw;
  logic signed [CW+1:0] rx, ry;
  logic               step_ok;
  logic [AW-1:0]      step_addr, end_addr;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [LW-1:0]      mem_wdata, mem_rdata;

  logic signed [CW:0] dx, dy;
  logic [CW:0]        adx, ady;
  logic               in_acc, out_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign eff_w = (SW'(grid_width_q) > SW'(MAX_GRID_WIDTH)) ? SW'(MAX_GRID_WIDTH)
                                                            : SW'(grid_width_q);
  assign eff_h = (SW'(grid_height_q) > SW'(MAX_GRID_HEIGHT)) ? SW'(MAX_GRID_HEIGHT)
                                                              : SW'(grid_height_q);

  always_comb begin
    unique case (conv_idx_q)
      2'd0: mul_a = diff33(in_sx_q, origin_x_q);
      2'd1: mul_a = diff33(in_sy_q, origin_y_q);
      2'd2: mul_a = diff33(in_px_q, origin_x_q);
      default: mul_a = diff33(in_py_q, origin_y_q);
    endcase
  end

  ogrup_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (cpm_q),
    .p_o   (mul_p)
  );

  assign conv_cell = mul_p[57:32];
  assign conv_eff = conv_idx_q[0] ? 26'(eff_h) : 26'(eff_w);
  assign conv_in = !conv_cell[25] && (26'(conv_cell) < conv_eff);

  assign dx = $signed({1'b0, cell_q[2]}) - $signed({1'b0, cell_q[0]});
  assign dy = $signed({1'b0, cell_q[3]}) - $signed({1'b0, cell_q[1]});
  assign adx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
  assign ady = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);

  assign div_dividend = (state_q == ST_DIV_Y) ? {ady_q, 16'b0} : {adx_q, 16'b0};
  assign div_divisor = steps_q;

  ogrup_div #(
    .DW (DVW),
    .VW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign div_q = {1'b0, div_quot[16:0]};
  assign div_inc = ((state_q == ST_WAIT_Y) ? dyneg_q : dxneg_q) ? -div_q : div_q;

  assign rxw = posx_q + PW'(32768);
  assign ryw = posy_q + PW'(32768);
  assign rx = rxw[PW-1:16];
  assign ry = ryw[PW-1:16];
  assign step_ok = !rx[CW+1] && !ry[CW+1] &&
                   (26'(rx[CW:0]) < 26'(eff_w)) && (26'(ry[CW:0]) < 26'(eff_h));
  assign step_addr = AW'(ry[CW-1:0]) * AW'(MAX_GRID_WIDTH) + AW'(rx[CW-1:0]);
  assign end_addr = AW'(cell_q[3]) * AW'(MAX_GRID_WIDTH) + AW'(cell_q[2]);

  ogrup_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (LW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = cur_addr_q;
    mem_wdata = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ACT_RAY || s_axis_tuser == ACT_QUERY) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_MUL: state_d = ST_CAP;
      ST_CAP: state_d = (conv_idx_q == 2'd3) ? ST_PLAN : ST_MUL;
      ST_PLAN: begin
        if (act_q == ACT_QUERY) begin
          state_d = (cin_q[2] && cin_q[3]) ? ST_Q_RD : ST_OUT;
        end else if (!(&cin_q)) begin
          state_d = ST_OUT;
        end else if (adx == '0 && ady == '0) begin
          state_d = ST_END_RD;
        end else begin
          state_d = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        div_start = 1'b1;
        state_d = ST_WAIT_X;
      end
      ST_WAIT_X: if (div_done) state_d = ST_DIV_Y;
      ST_DIV_Y: begin
        div_start = 1'b1;
        state_d = ST_WAIT_Y;
      end
      ST_WAIT_Y: if (div_done) state_d = ST_STEP_RD;
      ST_STEP_RD: begin
        mem_re = 1'b1;
        mem_addr = step_addr;
        state_d = ST_STEP_WR;
      end
      ST_STEP_WR: begin
        mem_we = cur_ok_q;
        mem_wdata = sat_add(mem_rdata, miss_delta_q);
        state_d = (step_cnt_q + 1'b1 == steps_q) ? ST_END_RD : ST_STEP_RD;
      end
      ST_END_RD: begin
        mem_re = 1'b1;
        mem_addr = end_addr;
        state_d = ST_END_WR;
      end
      ST_END_WR: begin
        mem_we = 1'b1;
        mem_wdata = sat_add(mem_rdata, hit_delta_q);
        state_d = ST_OUT;
      end
      ST_Q_RD: begin
        mem_re = 1'b1;
        mem_addr = end_addr;
        state_d = ST_Q_WAIT;
      end
      ST_Q_WAIT: state_d = ST_OUT;
      ST_OUT: if (out_acc) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q <= '0;
      scans_q <= '0;
      out_valid_q <= 1'b0;
      grid_width_q <= RST_GRID_WIDTH;
      grid_height_q <= RST_GRID_HEIGHT;
      origin_x_q <= '0;
      origin_y_q <= '0;
      cpm_q <= RST_CELLS_PER_METER;
      hit_delta_q <= RST_HIT_DELTA;
      miss_delta_q <= RST_MISS_DELTA;
      spsm_q <= RST_SCANS_PER_SUBMAP;
    end else begin
      state_q <= state_d;
      out_valid_q <= (state_d == ST_OUT);
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (in_acc && s_axis_tuser == ACT_SCAN && scans_q != SCAN_SAT) begin
        scans_q <= scans_q + 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_GRID_WIDTH:       grid_width_q <= cfg_wdata_i[8:0];
          CFG_GRID_HEIGHT:      grid_height_q <= cfg_wdata_i[8:0];
          CFG_ORIGIN_X:         origin_x_q <= cfg_wdata_i;
          CFG_ORIGIN_Y:         origin_y_q <= cfg_wdata_i;
          CFG_CELLS_PER_METER:  cpm_q <= cfg_wdata_i[23:0];
          CFG_HIT_DELTA:        hit_delta_q <= cfg_wdata_i[LW-1:0];
          CFG_MISS_DELTA:       miss_delta_q <= cfg_wdata_i[LW-1:0];
          CFG_SCANS_PER_SUBMAP: spsm_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        act_q <= action_e'(s_axis_tuser);
        in_sx_q <= s_axis_tdata[31:0];
        in_sy_q <= s_axis_tdata[63:32];
        in_px_q <= s_axis_tdata[95:64];
        in_py_q <= s_axis_tdata[127:96];
        conv_idx_q <= 2'd0;
        out_lo_q <= '0;
        out_inmap_q <= 1'b0;
        out_applied_q <= 1'b0;
      end
      ST_CAP: begin
        cell_q[conv_idx_q] <= conv_cell[CW-1:0];
        cin_q[conv_idx_q] <= conv_in;
        conv_idx_q <= conv_idx_q + 1'b1;
      end
      ST_PLAN: begin
        adx_q <= adx[CW-1:0];
        ady_q <= ady[CW-1:0];
        dxneg_q <= dx[CW];
        dyneg_q <= dy[CW];
        steps_q <= (adx > ady) ? adx[CW-1:0] : ady[CW-1:0];
        step_cnt_q <= '0;
        posx_q <= $signed({2'b0, cell_q[0], 16'b0});
        posy_q <= $signed({2'b0, cell_q[1], 16'b0});
      end
      ST_WAIT_X: if (div_done) incx_q <= div_inc;
      ST_WAIT_Y: if (div_done) incy_q <= div_inc;
      ST_STEP_RD: begin
        cur_addr_q <= step_addr;
        cur_ok_q <= step_ok;
      end
      ST_STEP_WR: begin
        posx_q <= posx_q + PW'(incx_q);
        posy_q <= posy_q + PW'(incy_q);
        step_cnt_q <= step_cnt_q + 1'b1;
      end
      ST_END_RD: cur_addr_q <= end_addr;
      ST_END_WR: out_applied_q <= 1'b1;
      ST_Q_WAIT: begin
        out_lo_q <= mem_rdata;
        out_inmap_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {scans_q >= SCAN_ENOUGH,
                         (scans_q != '0) && (scans_q >= spsm_q),
                         scans_q, out_applied_q, out_inmap_q, out_lo_q};

  a_ready_excl_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is held");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_inmap_q && out_applied_q))
    else $error("query and ray flags both set");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP_WR) |-> (step_cnt_q < steps_q))
    else $error("ray walk past its step count");

endmodule
